// ===== rtl/core/mrr_pkg.sv =====
// ----------------------------------------------------------------------------
// mrr_pkg: shared types and constants
// Types and constants used by the multi-word residue decomposition block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrr_pkg;

   // Number of modulus registers and residue lanes.
   localparam int NUM_LANES = 3;

   // Word and modulus widths.
   localparam int WORD_W    = 64;
   localparam int MODULUS_W = 62;

   // Bit-serial reduction runs over a two-word dividend.
   localparam int DIVIDEND_W = 2 * WORD_W;
   localparam int STEP_W     = $clog2(DIVIDEND_W);

   // Configuration port.
   localparam int ADDR_W = 5;
   localparam int DATA_W = 64;

   // Register indexes, taken from paddr[4:3].
   localparam logic [1:0] REG_COUNT       = 2'd0;
   localparam logic [1:0] REG_MODULUS_ZERO = 2'd1;
   localparam logic [1:0] REG_MODULUS_ONE  = 2'd2;
   localparam logic [1:0] REG_MODULUS_TWO  = 2'd3;

   // Reset values of the registers.
   localparam logic [1:0]           COUNT_RESET   = 2'd3;
   localparam logic [MODULUS_W-1:0] MODULUS_ZERO_RESET = 62'd4611686018326724609;
   localparam logic [MODULUS_W-1:0] MODULUS_ONE_RESET  = 62'd4611686018309947393;
   localparam logic [MODULUS_W-1:0] MODULUS_TWO_RESET  = 62'd4611686018282684417;

   typedef logic [WORD_W-1:0]    word_type;
   typedef logic [MODULUS_W-1:0] modulus_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;        // first word: copy into every remainder
      logic       start;       // later word: set up the reduction
      logic       step;        // one bit of restoring reduction
      logic       finish;      // write the reduced value back
      logic       emit;        // load a residue into the output register
      logic [1:0] emit_index;
      logic       emit_last;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/multiword_rns_residue.sv =====
// ----------------------------------------------------------------------------
// multiword_rns_residue: multi-word integer to residue decomposition
// Reduces multi-word integers modulo up to three configured moduli.
// ----------------------------------------------------------------------------
// Each integer arrives as one 64-bit beat per active modulus, most
// significant word first; after its last word the block sends one residue
// beat per active modulus, in modulus order, with rsp_last_residue set on the
// final one. The first word of an integer is copied into every remainder.
// Each later word is accepted, then the 128-bit value {remainder, word} goes
// through the bit-serial restoring reduction, which runs in all three lanes
// at once, and the remainders are written back. The residues then leave at
// one beat per cycle while the output is not stalled, and the next word is
// taken as soon as the last residue sits in the output register. Registers
// are written over the APB-style port at byte address 8*i: modulus_count,
// then moduli zero to two; write them only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module multiword_rns_residue
   import mrr_pkg::*;
#(
   parameter int MAX_MODULI = 3
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // Word input channel.
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [WORD_W-1:0] req_word,
   // Residue output channel.
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [WORD_W-1:0] rsp_residue,
   output logic      [1:0]        rsp_modulus_index,
   output logic                   rsp_last_residue,
   // Configuration port.
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready
);

   logic [1:0]                          modulus_count;
   logic [NUM_LANES-1:0][MODULUS_W-1:0] moduli;
   ctrl_cmd_type                        cmd;
   dp_status_type                       status;

   // Configuration registers.
   mrr_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .modulus_count (modulus_count),
      .moduli        (moduli)
   );

   // Controller.
   mrr_ctrl #(
      .MAX_MODULI (MAX_MODULI)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .modulus_count (modulus_count),
      .status        (status),
      .cmd           (cmd)
   );

   // Datapath.
   mrr_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .word              (req_word),
      .moduli            (moduli),
      .rsp_stall         (rsp_stall),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_residue       (rsp_residue),
      .rsp_modulus_index (rsp_modulus_index),
      .rsp_last_residue  (rsp_last_residue)
   );

endmodule

`default_nettype wire

// ===== rtl/core/mrr_csr.sv =====
// ----------------------------------------------------------------------------
// mrr_csr: configuration registers
// APB-style register file holding the modulus count and the three moduli.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrr_csr
   import mrr_pkg::*;
(
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [ADDR_W-1:0]                   paddr,
   input  wire logic [DATA_W-1:0]                   pwdata,
   output logic      [DATA_W-1:0]                   prdata,
   output logic                                     pready,
   output logic      [1:0]                          modulus_count,
   output logic      [NUM_LANES-1:0][MODULUS_W-1:0] moduli
);

   logic [1:0]  count_ff, count_in;
   modulus_type mod0_ff, mod0_in;
   modulus_type mod1_ff, mod1_in;
   modulus_type mod2_ff, mod2_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   // Write decode.
   always_comb begin
      count_in = count_ff;
      mod0_in  = mod0_ff;
      mod1_in  = mod1_ff;
      mod2_in  = mod2_ff;
      if (wr_en) begin
         unique case (paddr[4:3])
            REG_COUNT:        count_in = pwdata[1:0];
            REG_MODULUS_ZERO: mod0_in  = pwdata[MODULUS_W-1:0];
            REG_MODULUS_ONE:  mod1_in  = pwdata[MODULUS_W-1:0];
            REG_MODULUS_TWO:  mod2_in  = pwdata[MODULUS_W-1:0];
            default:          count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
         mod0_ff  <= MODULUS_ZERO_RESET;
         mod1_ff  <= MODULUS_ONE_RESET;
         mod2_ff  <= MODULUS_TWO_RESET;
      end else begin
         count_ff <= count_in;
         mod0_ff  <= mod0_in;
         mod1_ff  <= mod1_in;
         mod2_ff  <= mod2_in;
      end
   end

   // Read decode.
   always_comb begin
      unique case (paddr[4:3])
         REG_COUNT:        prdata = {{(DATA_W-2){1'b0}}, count_ff};
         REG_MODULUS_ZERO: prdata = {{(DATA_W-MODULUS_W){1'b0}}, mod0_ff};
         REG_MODULUS_ONE:  prdata = {{(DATA_W-MODULUS_W){1'b0}}, mod1_ff};
         REG_MODULUS_TWO:  prdata = {{(DATA_W-MODULUS_W){1'b0}}, mod2_ff};
         default:          prdata = '0;
      endcase
   end

   assign modulus_count = count_ff;
   assign moduli[0]     = mod0_ff;
   assign moduli[1]     = mod1_ff;
   assign moduli[2]     = mod2_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mrr_lane.sv =====
// ----------------------------------------------------------------------------
// mrr_lane: one residue lane
// Holds the running remainder for one modulus and reduces the two-word value
// {remainder, word} modulo that modulus one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrr_lane
   import mrr_pkg::*;
(
   input  wire logic         clock,
   input  wire ctrl_cmd_type cmd,
   input  wire word_type     word,
   input  wire modulus_type  modulus,
   output word_type          remainder
);

   word_type                rem_ff, rem_in;
   logic [DIVIDEND_W-1:0]   shift_ff, shift_in;
   modulus_type             acc_ff, acc_in;
   logic [MODULUS_W:0]      trial;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   // The accumulator stays below the modulus, so one subtraction suffices.
   always_comb begin
      trial = {acc_ff, shift_ff[DIVIDEND_W-1]};
      if (trial >= {1'b0, modulus}) begin
         trial = trial - {1'b0, modulus};
      end
   end

   always_comb begin
      rem_in   = rem_ff;
      shift_in = shift_ff;
      acc_in   = acc_ff;
      if (cmd.load) begin
         rem_in = word;
      end
      if (cmd.start) begin
         shift_in = {rem_ff, word};
         acc_in   = '0;
      end
      if (cmd.step) begin
         shift_in = {shift_ff[DIVIDEND_W-2:0], 1'b0};
         acc_in   = trial[MODULUS_W-1:0];
      end
      // A zero modulus gives a zero residue.
      if (cmd.finish) begin
         rem_in = (modulus == '0) ? '0 : {{(WORD_W-MODULUS_W){1'b0}}, acc_ff};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      acc_ff   <= acc_in;
   end

   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mrr_datapath.sv =====
// ----------------------------------------------------------------------------
// mrr_datapath: residue datapath
// Three residue lanes and the result output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrr_datapath
   import mrr_pkg::*;
(
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ctrl_cmd_type                        cmd,
   input  wire word_type                            word,
   input  wire logic [NUM_LANES-1:0][MODULUS_W-1:0] moduli,
   input  wire logic                                rsp_stall,
   output dp_status_type                            status,
   output logic                                     rsp_valid,
   output word_type                                 rsp_residue,
   output logic      [1:0]                          rsp_modulus_index,
   output logic                                     rsp_last_residue
);

   word_type   lane_rem [NUM_LANES];
   word_type   sel_rem;
   logic       valid_ff, valid_in;
   word_type   residue_ff, residue_in;
   logic [1:0] index_ff, index_in;
   logic       last_ff, last_in;

   // Residue lanes, one per modulus register.
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      mrr_lane u_lane (
         .clock     (clock),
         .cmd       (cmd),
         .word      (word),
         .modulus   (moduli[g]),
         .remainder (lane_rem[g])
      );
   end

   // Select the residue being emitted.
   always_comb begin
      case (cmd.emit_index)
         2'd0:    sel_rem = lane_rem[0];
         2'd1:    sel_rem = lane_rem[1];
         2'd2:    sel_rem = lane_rem[2];
         default: sel_rem = '0;
      endcase
   end

   // Output register: free when empty or when its beat leaves this cycle.
   assign status.out_free = ~valid_ff | ~rsp_stall;

   always_comb begin
      valid_in   = valid_ff & rsp_stall;
      residue_in = residue_ff;
      index_in   = index_ff;
      last_in    = last_ff;
      if (cmd.emit) begin
         valid_in   = 1'b1;
         residue_in = sel_rem;
         index_in   = cmd.emit_index;
         last_in    = cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      residue_ff <= residue_in;
      index_ff   <= index_in;
      last_ff    <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_residue       = residue_ff;
   assign rsp_modulus_index = index_ff;
   assign rsp_last_residue  = last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mrr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrr_ctrl: sequencing controller
// Tracks the word position in the integer, runs the bit-serial reduction
// and steps through the residues at the end of an integer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrr_ctrl
   import mrr_pkg::*;
#(
   parameter int MAX_MODULI = 3
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [1:0]    modulus_count,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_REDUCE = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   // Largest active count: the parameter, limited to the modulus registers.
   localparam int         CAP_INT = (MAX_MODULI < NUM_LANES) ? MAX_MODULI : NUM_LANES;
   localparam logic [1:0] CAP     = CAP_INT[1:0];
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

   logic [1:0]        state_ff, state_in;
   logic [1:0]        wp_ff, wp_in;
   logic [1:0]        n_ff, n_in;
   logic              close_ff, close_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [1:0]        idx_ff, idx_in;
   logic [1:0]        n_act;
   logic              accept;
   logic              close_now;

   // Active modulus count: zero acts as one, capped at the parameter.
   always_comb begin
      n_act = (modulus_count == 2'd0) ? 2'd1 : modulus_count;
      if (n_act > CAP) begin
         n_act = CAP;
      end
   end

   assign accept    = (state_ff == ST_IDLE) & req_valid;
   assign close_now = ({1'b0, wp_ff} + 3'd1) >= {1'b0, n_act};
   assign req_stall = (state_ff != ST_IDLE);

   // Commands to the datapath.
   always_comb begin
      cmd            = '0;
      cmd.load       = accept & (wp_ff == 2'd0);
      cmd.start      = accept & (wp_ff != 2'd0);
      cmd.step       = (state_ff == ST_REDUCE);
      cmd.finish     = (state_ff == ST_FINISH);
      cmd.emit       = (state_ff == ST_EMIT) & status.out_free;
      cmd.emit_index = idx_ff;
      cmd.emit_last  = (idx_ff == (n_ff - 2'd1));
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      wp_in    = wp_ff;
      n_in     = n_ff;
      close_in = close_ff;
      step_in  = step_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               n_in     = n_act;
               close_in = close_now;
               idx_in   = 2'd0;
               step_in  = '0;
               if (wp_ff != 2'd0) begin
                  state_in = ST_REDUCE;
               end else if (close_now) begin
                  wp_in    = 2'd0;
                  state_in = ST_EMIT;
               end else begin
                  wp_in = 2'd1;
               end
            end
         end
         ST_REDUCE: begin
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (close_ff) begin
               wp_in    = 2'd0;
               state_in = ST_EMIT;
            end else begin
               wp_in    = wp_ff + 2'd1;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (cmd.emit) begin
               idx_in = idx_ff + 2'd1;
               if (cmd.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wp_ff    <= 2'd0;
         n_ff     <= 2'd1;
         close_ff <= 1'b0;
         step_ff  <= '0;
         idx_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         n_ff     <= n_in;
         close_ff <= close_in;
         step_ff  <= step_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire
